// File: sv/dnsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS name decompressor package
// Shared types and fixed constants for the name decompressor block.
// ----------------------------------------------------------------------------
package dnsd_pkg;

    // Fixed field widths.
    localparam int ADDR_W    = 9;    // byte_address input
    localparam int POS_W     = 15;   // walk position, covers any pointer target plus a label
    localparam int LEN_W     = 6;    // label length / pointer high bits
    localparam int CNT_W     = 4;    // characters in one result, 0..8
    localparam int HOPS_W    = 4;
    localparam int CHARS_W   = 8;
    localparam int SIZE_W    = 9;    // encoded size before capping
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // Operation codes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [HOPS_W-1:0]  HOPS_RESET = 4'd10;
    localparam logic [CHARS_W-1:0] NAME_RESET = 8'd255;

    // Name encoding constants.
    localparam logic [1:0]        PTR_MARK  = 2'b11;
    localparam logic [7:0]        DOT_CHAR  = 8'h2E;
    localparam logic [SIZE_W-1:0] SIZE_CAP  = 9'd255;
    localparam logic [CNT_W-1:0]  PACK_FULL = 4'd8;

    // One queued command from the front to the back.
    typedef struct packed {
        logic              is_decode;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
    } t_cmd;

    // Configuration seen by the walker.
    typedef struct packed {
        logic [HOPS_W-1:0]  max_hops;
        logic [CHARS_W-1:0] max_chars;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [63:0]        chars;
        logic [CNT_W-1:0]   char_count;
        logic               last;
        logic [7:0]         name_length;
        logic [7:0]         encoded_size;
        logic               hop_limit_hit;
        logic               truncated;
        logic               out_of_range;
    } t_result;

endpackage

// File: sv/dnsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dnsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and a read port that holds its data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/dnsd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small synchronous FIFO
// Register-based queue with full and empty flags and a show-ahead head.
// ----------------------------------------------------------------------------
module dnsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer wrap and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: sv/dnsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Name decompressor front end
// Accepts input items, drops writes beyond the store and queues the rest.
// ----------------------------------------------------------------------------
module dnsd_front #(
    parameter int STORE_BYTES = 512,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_operation,
    input  logic [dnsd_pkg::ADDR_W-1:0] i_byte_address,
    input  logic [7:0]            i_byte_value,
    output logic                  o_full,
    input  logic                  i_cmd_pop,
    output logic                  o_cmd_empty,
    output dnsd_pkg::t_cmd        o_cmd
);

    import dnsd_pkg::*;

    t_cmd w_cmd;
    logic w_in_range;
    logic w_keep;

    // A write outside the store has no effect, so it never enters the queue.
    assign w_in_range    = (POS_W'(i_byte_address) < POS_W'(STORE_BYTES));
    assign w_keep        = (i_operation == OP_DECODE) || w_in_range;
    assign w_cmd.is_decode = (i_operation == OP_DECODE);
    assign w_cmd.addr    = i_byte_address;
    assign w_cmd.value   = i_byte_value;

    dnsd_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full && w_keep),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

// File: sv/dnsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Name decompressor back end
// Performs store writes and walks names through labels and pointers.
// ----------------------------------------------------------------------------
module dnsd_back #(
    parameter int STORE_BYTES = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_empty,
    input  dnsd_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_pop,
    input  dnsd_pkg::t_cfg                 i_cfg,
    output logic                           o_ram_we,
    output logic [$clog2(STORE_BYTES)-1:0] o_ram_waddr,
    output logic [7:0]                     o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(STORE_BYTES)-1:0] o_ram_raddr,
    input  logic [7:0]                     i_ram_rdata,
    input  logic                           i_res_full,
    output logic                           o_res_push,
    output dnsd_pkg::t_result              o_res
);

    import dnsd_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    // Walker states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FETCH_LEN = 4'd1;
    localparam logic [3:0] S_LEN       = 4'd2;
    localparam logic [3:0] S_PTR_LO    = 4'd3;
    localparam logic [3:0] S_DOT       = 4'd4;
    localparam logic [3:0] S_CHAR_RD   = 4'd5;
    localparam logic [3:0] S_CHAR_WR   = 4'd6;
    localparam logic [3:0] S_ES_INIT   = 4'd7;
    localparam logic [3:0] S_ES_FETCH  = 4'd8;
    localparam logic [3:0] S_ES_LEN    = 4'd9;
    localparam logic [3:0] S_FINAL     = 4'd10;

    logic [3:0]         r_state,   n_state;
    logic [POS_W-1:0]   r_pos,     n_pos;
    logic [ADDR_W-1:0]  r_start,   n_start;
    logic [CHARS_W-1:0] r_nlen,    n_nlen;
    logic [HOPS_W-1:0]  r_hops,    n_hops;
    logic [LEN_W-1:0]   r_rem,     n_rem;
    logic [LEN_W-1:0]   r_hi,      n_hi;
    logic [SIZE_W-1:0]  r_size,    n_size;
    logic [63:0]        r_pack,    n_pack;
    logic [CNT_W-1:0]   r_pcnt,    n_pcnt;
    logic               r_oor,     n_oor;
    logic               r_hop_hit, n_hop_hit;
    logic               r_trunc,   n_trunc;

    logic [POS_W-1:0]   w_cmd_pos;
    logic [POS_W-1:0]   w_pos_inc;
    logic               w_pos_in;
    logic               w_pos_inc_in;
    logic [LEN_W-1:0]   w_len;
    logic               w_is_ptr;
    logic               w_pack_full;
    logic               w_can_add;
    logic [7:0]         w_char;
    logic [63:0]        w_pack_app;

    assign w_cmd_pos    = POS_W'(i_cmd.addr);
    assign w_pos_inc    = r_pos + 1'b1;
    assign w_pos_in     = (r_pos < POS_W'(STORE_BYTES));
    assign w_pos_inc_in = (w_pos_inc < POS_W'(STORE_BYTES));
    assign w_len        = i_ram_rdata[LEN_W-1:0];
    assign w_is_ptr     = (i_ram_rdata[7:6] == PTR_MARK);
    assign w_pack_full  = (r_pcnt == PACK_FULL);
    assign w_can_add    = !w_pack_full || !i_res_full;
    assign w_char       = (r_state == S_DOT) ? DOT_CHAR : i_ram_rdata;

    // Character placed at the next free byte of the result word.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_pack_app[8*j +: 8] = (CNT_W'(j) == r_pcnt) ? w_char : r_pack[8*j +: 8];
        end
    end

    // Walk sequencer.
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_start   = r_start;
        n_nlen    = r_nlen;
        n_hops    = r_hops;
        n_rem     = r_rem;
        n_hi      = r_hi;
        n_size    = r_size;
        n_pack    = r_pack;
        n_pcnt    = r_pcnt;
        n_oor     = r_oor;
        n_hop_hit = r_hop_hit;
        n_trunc   = r_trunc;

        o_cmd_pop   = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = w_cmd_pos[AW-1:0];
        o_ram_wdata = i_cmd.value;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_pos[AW-1:0];
        o_res_push  = 1'b0;
        o_res       = '0;

        // A full result word goes out before the next character starts a new one.
        if ((r_state == S_DOT || r_state == S_CHAR_WR) && w_pack_full && w_can_add) begin
            o_res_push       = 1'b1;
            o_res.chars      = r_pack;
            o_res.char_count = PACK_FULL;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_decode) begin
                        n_pos     = w_cmd_pos;
                        n_start   = i_cmd.addr;
                        n_nlen    = '0;
                        n_hops    = '0;
                        n_pack    = '0;
                        n_pcnt    = '0;
                        n_oor     = 1'b0;
                        n_hop_hit = 1'b0;
                        n_trunc   = 1'b0;
                        n_state   = S_FETCH_LEN;
                    end else begin
                        o_ram_we = 1'b1;
                    end
                end
            end
            S_FETCH_LEN: begin
                if (!w_pos_in) begin
                    n_oor   = 1'b1;
                    n_state = S_ES_INIT;
                end else begin
                    o_ram_re = 1'b1;
                    n_state  = S_LEN;
                end
            end
            S_LEN: begin
                if (w_is_ptr) begin
                    if (r_hops >= i_cfg.max_hops) begin
                        n_hop_hit = 1'b1;
                        n_state   = S_ES_INIT;
                    end else if (!w_pos_inc_in) begin
                        n_oor   = 1'b1;
                        n_state = S_ES_INIT;
                    end else begin
                        n_hi        = w_len;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = w_pos_inc[AW-1:0];
                        n_state     = S_PTR_LO;
                    end
                end else begin
                    n_pos = w_pos_inc;
                    n_rem = w_len;
                    if (w_len == '0) begin
                        n_state = S_ES_INIT;
                    end else if (r_nlen == '0) begin
                        n_state = S_CHAR_RD;
                    end else if (r_nlen >= i_cfg.max_chars) begin
                        n_trunc = 1'b1;
                        n_state = S_ES_INIT;
                    end else begin
                        n_state = S_DOT;
                    end
                end
            end
            S_PTR_LO: begin
                n_pos   = POS_W'({r_hi, i_ram_rdata});
                n_hops  = r_hops + 1'b1;
                n_state = S_FETCH_LEN;
            end
            S_DOT: begin
                if (w_can_add) begin
                    n_pack  = w_pack_full ? {56'd0, w_char} : w_pack_app;
                    n_pcnt  = w_pack_full ? CNT_W'(1) : r_pcnt + 1'b1;
                    n_nlen  = r_nlen + 1'b1;
                    n_state = S_CHAR_RD;
                end
            end
            S_CHAR_RD: begin
                if (r_rem == '0) begin
                    n_state = S_FETCH_LEN;
                end else if (r_nlen >= i_cfg.max_chars) begin
                    n_trunc = 1'b1;
                    n_state = S_ES_INIT;
                end else if (!w_pos_in) begin
                    n_oor   = 1'b1;
                    n_state = S_ES_INIT;
                end else begin
                    o_ram_re = 1'b1;
                    n_state  = S_CHAR_WR;
                end
            end
            S_CHAR_WR: begin
                if (w_can_add) begin
                    n_pack  = w_pack_full ? {56'd0, w_char} : w_pack_app;
                    n_pcnt  = w_pack_full ? CNT_W'(1) : r_pcnt + 1'b1;
                    n_nlen  = r_nlen + 1'b1;
                    n_pos   = w_pos_inc;
                    n_rem   = r_rem - 1'b1;
                    n_state = S_CHAR_RD;
                end
            end
            S_ES_INIT: begin
                n_pos   = POS_W'(r_start);
                n_size  = '0;
                n_state = S_ES_FETCH;
            end
            S_ES_FETCH: begin
                if (r_size >= SIZE_CAP) begin
                    n_state = S_FINAL;
                end else if (!w_pos_in) begin
                    // Beyond the store reads as a terminator.
                    n_oor   = 1'b1;
                    n_size  = r_size + 1'b1;
                    n_state = S_FINAL;
                end else begin
                    o_ram_re = 1'b1;
                    n_state  = S_ES_LEN;
                end
            end
            S_ES_LEN: begin
                if (w_is_ptr) begin
                    n_size  = r_size + SIZE_W'(2);
                    n_state = S_FINAL;
                end else if (w_len == '0) begin
                    n_size  = r_size + 1'b1;
                    n_state = S_FINAL;
                end else begin
                    n_size  = r_size + SIZE_W'(w_len) + 1'b1;
                    n_pos   = r_pos + POS_W'(w_len) + 1'b1;
                    n_state = S_ES_FETCH;
                end
            end
            S_FINAL: begin
                if (!i_res_full) begin
                    o_res_push         = 1'b1;
                    o_res.chars        = r_pack;
                    o_res.char_count   = r_pcnt;
                    o_res.last         = 1'b1;
                    o_res.name_length  = r_nlen;
                    o_res.encoded_size = (r_size > SIZE_CAP) ? 8'd255 : r_size[7:0];
                    o_res.hop_limit_hit = r_hop_hit;
                    o_res.truncated    = r_trunc;
                    o_res.out_of_range = r_oor;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk context; every field is loaded before use.
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_start   <= n_start;
        r_nlen    <= n_nlen;
        r_hops    <= n_hops;
        r_rem     <= n_rem;
        r_hi      <= n_hi;
        r_size    <= n_size;
        r_pack    <= n_pack;
        r_pcnt    <= n_pcnt;
        r_oor     <= n_oor;
        r_hop_hit <= n_hop_hit;
        r_trunc   <= n_trunc;
    end

endmodule

// File: sv/dns_name_decompressor_unit.sv
// A byte write passes through the command queue and is stored by the back end while idle;
// writes sustain one per cycle while no decode is in progress. A decode reads the store
// one byte at a time through the single read port: label lengths, characters and pointers,
// then the length bytes of the encoded-size walk, and finally emits the last result.
// Reset is synchronous and clears queues, walker state and configuration; the store
// keeps undefined contents until written, with no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS name decompressor
// Message byte store with a label/pointer walker that emits dotted names.
// ----------------------------------------------------------------------------
module dns_name_decompressor_unit #(
    parameter int STORE_BYTES = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input queue side
    input  logic                              push,
    output logic                              full,
    input  logic                              i_operation,
    input  logic [dnsd_pkg::ADDR_W-1:0]       i_byte_address,
    input  logic [7:0]                        i_byte_value,
    // Result queue side
    output logic                              empty,
    input  logic                              pop,
    output logic [63:0]                       o_chars,
    output logic [dnsd_pkg::CNT_W-1:0]        o_char_count,
    output logic                              o_last,
    output logic [7:0]                        o_name_length,
    output logic [7:0]                        o_encoded_size,
    output logic                              o_hop_limit_hit,
    output logic                              o_truncated,
    output logic                              o_out_of_range,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [dnsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dnsd_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    import dnsd_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic [HOPS_W-1:0]  r_max_hops;
    logic [CHARS_W-1:0] r_max_chars;
    t_cfg               w_cfg;
    t_cmd               w_cmd;
    logic               w_cmd_empty;
    logic               w_cmd_pop;
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    logic [7:0]         w_ram_wdata;
    logic               w_ram_re;
    logic [AW-1:0]      w_ram_raddr;
    logic [7:0]         w_ram_rdata;
    logic               w_res_full;
    logic               w_res_push;
    t_result            w_res;
    t_result            w_res_head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hops  <= HOPS_RESET;
            r_max_chars <= NAME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_HOPS:  r_max_hops  <= i_cfg_data[HOPS_W-1:0];
                CFG_MAX_CHARS: r_max_chars <= i_cfg_data[CHARS_W-1:0];
                default:       r_max_hops  <= r_max_hops;
            endcase
        end
    end

    assign w_cfg.max_hops  = r_max_hops;
    assign w_cfg.max_chars = r_max_chars;

    // Front end: accept and queue commands.
    dnsd_front #(
        .STORE_BYTES (STORE_BYTES),
        .QUEUE_DEPTH (4)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_operation    (i_operation),
        .i_byte_address (i_byte_address),
        .i_byte_value   (i_byte_value),
        .o_full         (full),
        .i_cmd_pop      (w_cmd_pop),
        .o_cmd_empty    (w_cmd_empty),
        .o_cmd          (w_cmd)
    );

    // Message store.
    dnsd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Back end: writes and name walks.
    dnsd_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg       (w_cfg),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // Result queue decouples the walker from the consumer.
    dnsd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (4)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_head),
        .o_empty (empty)
    );

    assign o_chars         = w_res_head.chars;
    assign o_char_count    = w_res_head.char_count;
    assign o_last          = w_res_head.last;
    assign o_name_length   = w_res_head.name_length;
    assign o_encoded_size  = w_res_head.encoded_size;
    assign o_hop_limit_hit = w_res_head.hop_limit_hit;
    assign o_truncated     = w_res_head.truncated;
    assign o_out_of_range  = w_res_head.out_of_range;

endmodule

// File: sv/dnsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Name decompressor port checker
// Watches the top-level ports for reset, result shape and hold behavior.
// ----------------------------------------------------------------------------
module dnsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] o_chars,
    input logic [3:0]  o_char_count,
    input logic        o_last,
    input logic [7:0]  o_name_length,
    input logic [7:0]  o_encoded_size,
    input logic        o_hop_limit_hit,
    input logic        o_truncated,
    input logic        o_out_of_range
);

    // Reset leaves the result queue empty and the input queue not full.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // A waiting result holds until its transfer.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_chars) && $stable(o_last)
                           && $stable(o_char_count))
        else $error("waiting result changed before transfer");

    // Only the final result of a name may be partial or carry summary fields.
    a_middle_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_last |-> o_char_count == 4'd8 && o_name_length == 8'd0
                              && o_encoded_size == 8'd0 && !o_hop_limit_hit
                              && !o_truncated && !o_out_of_range)
        else $error("non-final result has wrong shape");

    // The final character count agrees with the total name length.
    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_last |-> o_char_count <= 4'd8
                             && o_name_length[2:0] == o_char_count[2:0]
                             && ((o_char_count == 4'd0) == (o_name_length == 8'd0)))
        else $error("final count inconsistent with name length");

    // Every name occupies at least its terminator or pointer.
    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_last |-> o_encoded_size != 8'd0)
        else $error("final result with zero encoded size");

endmodule

bind dns_name_decompressor_unit dnsd_checker u_dnsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_chars         (o_chars),
    .o_char_count    (o_char_count),
    .o_last          (o_last),
    .o_name_length   (o_name_length),
    .o_encoded_size  (o_encoded_size),
    .o_hop_limit_hit (o_hop_limit_hit),
    .o_truncated     (o_truncated),
    .o_out_of_range  (o_out_of_range)
);
